// ===== rtl/core/kxrcf_pkg.sv =====
`default_nettype none
package kxrcf_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int WGT_W     = DATA_W - 1;
  localparam int NRM_W     = 18;
  localparam int ACC_W     = 64;
  localparam int WJ_W      = 2 * WGT_W - FRAC_BITS;
  localparam int PROJ_W    = NRM_W + DATA_W - FRAC_BITS;
  localparam int VN_W      = PROJ_W + 1;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int MUL_AW    = 384;
  localparam int MUL_BW    = 128;
  localparam int MUL_CW    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int FC_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_COUNT = 2'd1;
  localparam logic [DATA_W-1:0]    THRESHOLD_RST  = 32'h0001_0000;
  localparam logic [FC_W-1:0]      FACE_COUNT_RST = 3'd3;
  localparam logic [FC_W-1:0]      FACE_LIMIT     = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WJ, OP_VOL, OP_NVX, OP_NVY,
    OP_FLOW_GO, OP_FLOW_ACC, OP_JUMP_GO, OP_JUMP_ACC, OP_FACE_END,
    OP_R1_GO, OP_R2_GO, OP_R3_GO, OP_R4_GO, OP_R5_GO, OP_LHS_GO, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WJ, ST_VOL, ST_NVX, ST_NVY,
    ST_FLOW_GO, ST_FLOW_RUN, ST_FLOW_ACC,
    ST_JUMP_GO, ST_JUMP_RUN, ST_JUMP_ACC, ST_FACE_END,
    ST_R1_GO, ST_R1_RUN, ST_R2_GO, ST_R2_RUN, ST_R3_GO, ST_R3_RUN,
    ST_R4_GO, ST_R4_RUN, ST_R5_GO, ST_R5_RUN, ST_LHS_GO, ST_LHS_RUN, ST_CMP
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic face_end;
    logic element_end;
    logic mul_busy;
  } dp_status_t;

  function automatic logic [ACC_W-1:0] sat_add_s(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W+1:0] b);
    logic signed [ACC_W+2:0] s;
    s = signed'({{3{a[ACC_W-1]}}, a}) + signed'({b[ACC_W+1], b});
    if (s > signed'({3'b000, 1'b0, {(ACC_W-1){1'b1}}}))
      return {1'b0, {(ACC_W-1){1'b1}}};
    else if (s < signed'({3'b111, 1'b1, {(ACC_W-1){1'b0}}}))
      return {1'b1, {(ACC_W-1){1'b0}}};
    else
      return s[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_add_u(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kxrcf_serial_mul.sv =====
`default_nettype none
module kxrcf_serial_mul
  import kxrcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MUL_AW-1:0] a_in,
  input  wire logic [MUL_BW-1:0] b_in,
  input  wire logic [MUL_CW-1:0] nbits,
  output logic                   busy,
  output logic [MUL_AW-1:0]      product
);

  logic              busy_r, busy_nxt;
  logic [MUL_CW-1:0] cnt_r, cnt_nxt;
  logic [MUL_AW-1:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [MUL_BW-1:0] b_r, b_nxt;

  // shift-and-add, one multiplier bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nbits;
      a_nxt    = a_in;
      b_nxt    = b_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = {a_r[MUL_AW-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[MUL_BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule
`default_nettype wire

// ===== rtl/core/kxrcf_datapath.sv =====
`default_nettype none
module kxrcf_datapath
  import kxrcf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  input  wire logic                 in_mode,
  input  wire logic                 in_last,
  input  wire logic [231:0]         in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  output logic                      troubled
);

  // captured request
  logic              mode_r, fend_r, eend_r;
  logic [DATA_W-1:0] din_r, dout_r, vx_r, vy_r;
  logic [WGT_W-1:0]  qw_r, jac_r;
  logic [NRM_W-1:0]  nx_r, ny_r;

  logic [DATA_W-1:0] thr_r;
  logic [FC_W-1:0]   fc_r;

  logic [WJ_W-1:0]   wj_r;
  logic [PROJ_W-1:0] px_r;
  logic [VN_W-1:0]   vn_r;
  logic [DATA_W-1:0] peak_r;
  logic [ACC_W-1:0]  area_r, fflow_r, fjump_r, flen_r, jtot_r, ltot_r;
  logic [MUL_AW-1:0] rhs_r;
  logic              troubled_r;

  logic              mul_start, mul_busy;
  logic [MUL_AW-1:0] mul_a, product;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_CW-1:0] mul_n;

  logic [2*WGT_W-1:0]      wj_full;
  logic signed [49:0]      pxv, pyv;
  logic [DATA_W-1:0]       din_mag;
  logic [VN_W-1:0]         vn_mag;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       diff_mag;
  logic [ACC_W-1:0]        jtot_mag;
  logic [FC_W-1:0]         fc_factor;
  logic signed [81:0]      term_full;
  logic [ACC_W+1:0]        term;

  assign wj_full  = qw_r * jac_r;
  assign pxv      = $signed({{32{nx_r[NRM_W-1]}}, nx_r}) * $signed({{18{vx_r[DATA_W-1]}}, vx_r});
  assign pyv      = $signed({{32{ny_r[NRM_W-1]}}, ny_r}) * $signed({{18{vy_r[DATA_W-1]}}, vy_r});
  assign din_mag  = din_r[DATA_W-1] ? (~din_r + 1'b1) : din_r;
  assign vn_mag   = vn_r[VN_W-1] ? (~vn_r + 1'b1) : vn_r;
  assign diff     = $signed({din_r[DATA_W-1], din_r}) - $signed({dout_r[DATA_W-1], dout_r});
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign jtot_mag = jtot_r[ACC_W-1] ? (~jtot_r + 1'b1) : jtot_r;
  assign fc_factor = (fc_r <= FACE_LIMIT) ? (FACE_LIMIT - fc_r) : '0;

  // signed product, floor shift by the fraction bits
  always_comb begin
    term_full = signed'({1'b0, product[80:0]});
    if ((cmd.op == OP_FLOW_ACC) ? vn_r[VN_W-1] : diff[DIFF_W-1])
      term_full = -term_full;
    term = term_full[81:FRAC_BITS];
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_n     = '0;
    unique case (cmd.op)
      OP_FLOW_GO: begin
        mul_start = 1'b1; mul_a = MUL_AW'(wj_r); mul_b = MUL_BW'(vn_mag);
        mul_n = MUL_CW'(VN_W);
      end
      OP_JUMP_GO: begin
        mul_start = 1'b1; mul_a = MUL_AW'(wj_r); mul_b = MUL_BW'(diff_mag);
        mul_n = MUL_CW'(DIFF_W);
      end
      OP_R1_GO: begin
        mul_start = 1'b1; mul_a = MUL_AW'(thr_r); mul_b = MUL_BW'(ltot_r);
        mul_n = MUL_CW'(ACC_W);
      end
      OP_R2_GO: begin
        mul_start = 1'b1; mul_a = product; mul_b = MUL_BW'(peak_r);
        mul_n = MUL_CW'(DATA_W);
      end
      OP_R3_GO: begin
        mul_start = 1'b1; mul_a = product; mul_b = product[MUL_BW-1:0];
        mul_n = MUL_CW'(MUL_BW);
      end
      OP_R4_GO: begin
        mul_start = 1'b1; mul_a = product; mul_b = MUL_BW'(fc_factor);
        mul_n = MUL_CW'(FC_W);
      end
      OP_R5_GO: begin
        mul_start = 1'b1; mul_a = product; mul_b = MUL_BW'(area_r);
        mul_n = MUL_CW'(ACC_W);
      end
      OP_LHS_GO: begin
        mul_start = 1'b1; mul_a = MUL_AW'(jtot_mag); mul_b = MUL_BW'(jtot_mag);
        mul_n = MUL_CW'(ACC_W);
      end
      default: ;
    endcase
  end

  kxrcf_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .nbits   (mul_n),
    .busy    (mul_busy),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RST;
      fc_r    <= FACE_COUNT_RST;
      peak_r  <= '0;
      area_r  <= '0;
      fflow_r <= '0;
      fjump_r <= '0;
      flen_r  <= '0;
      jtot_r  <= '0;
      ltot_r  <= '0;
    end else begin
      if (cfg_we && cfg_idx == REG_THRESHOLD)  thr_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_FACE_COUNT) fc_r  <= cfg_wdata[FC_W-1:0];
      unique case (cmd.op)
        OP_VOL: begin
          if (din_mag > peak_r) peak_r <= din_mag;
          area_r <= sat_add_u(area_r, ACC_W'(wj_r));
        end
        OP_FLOW_ACC: fflow_r <= sat_add_s(fflow_r, term);
        OP_JUMP_ACC: begin
          fjump_r <= sat_add_s(fjump_r, term);
          flen_r  <= sat_add_u(flen_r, ACC_W'(wj_r));
        end
        OP_FACE_END: begin
          if (fflow_r[ACC_W-1]) begin
            jtot_r <= sat_add_s(jtot_r, {{2{fjump_r[ACC_W-1]}}, fjump_r});
            ltot_r <= sat_add_u(ltot_r, flen_r);
          end
          fflow_r <= '0;
          fjump_r <= '0;
          flen_r  <= '0;
        end
        OP_EMIT: begin
          peak_r  <= '0;
          area_r  <= '0;
          fflow_r <= '0;
          fjump_r <= '0;
          flen_r  <= '0;
          jtot_r  <= '0;
          ltot_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r <= in_mode;
      eend_r <= in_last;
      din_r  <= in_data[31:0];
      dout_r <= in_data[63:32];
      qw_r   <= in_data[94:64];
      jac_r  <= in_data[125:95];
      vx_r   <= in_data[157:126];
      vy_r   <= in_data[189:158];
      nx_r   <= in_data[207:190];
      ny_r   <= in_data[225:208];
      fend_r <= in_data[226];
    end
    if (cmd.op == OP_WJ)     wj_r  <= wj_full[2*WGT_W-1:FRAC_BITS];
    if (cmd.op == OP_NVX)    px_r  <= pxv[49:FRAC_BITS];
    if (cmd.op == OP_NVY)    vn_r  <= {px_r[PROJ_W-1], px_r} +
                                      {pyv[49], pyv[49:FRAC_BITS]};
    if (cmd.op == OP_LHS_GO) rhs_r <= product;
    if (cmd.op == OP_EMIT)   troubled_r <= ({product[MUL_AW-1-5*FRAC_BITS:0],
                                             {(5*FRAC_BITS){1'b0}}} > rhs_r);
  end

  assign status   = '{mode: mode_r, face_end: fend_r, element_end: eend_r,
                      mul_busy: mul_busy};
  assign troubled = troubled_r;

endmodule
`default_nettype wire

// ===== rtl/core/kxrcf_ctrl.sv =====
`default_nettype none
module kxrcf_ctrl
  import kxrcf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_ok;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_WJ;
      ST_WJ:       state_nxt = status.mode ? ST_NVX : ST_VOL;
      ST_VOL:      state_nxt = status.element_end ? ST_R1_GO : ST_IDLE;
      ST_NVX:      state_nxt = ST_NVY;
      ST_NVY:      state_nxt = ST_FLOW_GO;
      ST_FLOW_GO:  state_nxt = ST_FLOW_RUN;
      ST_FLOW_RUN: if (!status.mul_busy) state_nxt = ST_FLOW_ACC;
      ST_FLOW_ACC: state_nxt = ST_JUMP_GO;
      ST_JUMP_GO:  state_nxt = ST_JUMP_RUN;
      ST_JUMP_RUN: if (!status.mul_busy) state_nxt = ST_JUMP_ACC;
      ST_JUMP_ACC: begin
        if (status.face_end)         state_nxt = ST_FACE_END;
        else if (status.element_end) state_nxt = ST_R1_GO;
        else                         state_nxt = ST_IDLE;
      end
      ST_FACE_END: state_nxt = status.element_end ? ST_R1_GO : ST_IDLE;
      ST_R1_GO:    state_nxt = ST_R1_RUN;
      ST_R1_RUN:   if (!status.mul_busy) state_nxt = ST_R2_GO;
      ST_R2_GO:    state_nxt = ST_R2_RUN;
      ST_R2_RUN:   if (!status.mul_busy) state_nxt = ST_R3_GO;
      ST_R3_GO:    state_nxt = ST_R3_RUN;
      ST_R3_RUN:   if (!status.mul_busy) state_nxt = ST_R4_GO;
      ST_R4_GO:    state_nxt = ST_R4_RUN;
      ST_R4_RUN:   if (!status.mul_busy) state_nxt = ST_R5_GO;
      ST_R5_GO:    state_nxt = ST_R5_RUN;
      ST_R5_RUN:   if (!status.mul_busy) state_nxt = ST_LHS_GO;
      ST_LHS_GO:   state_nxt = ST_LHS_RUN;
      ST_LHS_RUN:  if (!status.mul_busy) state_nxt = ST_CMP;
      ST_CMP:      if (emit_ok) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_WJ:       cmd.op = OP_WJ;
      ST_VOL:      cmd.op = OP_VOL;
      ST_NVX:      cmd.op = OP_NVX;
      ST_NVY:      cmd.op = OP_NVY;
      ST_FLOW_GO:  cmd.op = OP_FLOW_GO;
      ST_FLOW_ACC: cmd.op = OP_FLOW_ACC;
      ST_JUMP_GO:  cmd.op = OP_JUMP_GO;
      ST_JUMP_ACC: cmd.op = OP_JUMP_ACC;
      ST_FACE_END: cmd.op = OP_FACE_END;
      ST_R1_GO:    cmd.op = OP_R1_GO;
      ST_R2_GO:    cmd.op = OP_R2_GO;
      ST_R3_GO:    cmd.op = OP_R3_GO;
      ST_R4_GO:    cmd.op = OP_R4_GO;
      ST_R5_GO:    cmd.op = OP_R5_GO;
      ST_LHS_GO:   cmd.op = OP_LHS_GO;
      ST_CMP: begin
        if (emit_ok) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/kxrcf_troubled_cell_detect_unit.sv =====
`default_nettype none
// Channel  Direction  Signals                          Content
// in       slave      in_tvalid/tready/tdata/tuser/... one node request
// out      master     out_tvalid/tready/tdata          one flag per element
// cfg      write      cfg_valid/ready/index/data       threshold, face count
//
// A volume request runs the weight and volume steps; a face request runs the
// bit-serial multiplier twice, over 35 and 33 multiplier bits for the flow and jump products.
// Element end adds six serial products of 64, 32, 128, 3, 64 and 64 multiplier bits
// through the one shared shift-and-add unit, then a compare.
// Reset is synchronous on rst_n and restores threshold 1.0 and three faces.
// A flag waiting on out does not stop requests; only the next flag holds
// until the previous one has been taken.
module kxrcf_troubled_cell_detect_unit
  import kxrcf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // tdata from bit 0: depth_inner[31:0], depth_outer[63:32], quad_weight[94:64],
  // jacobian[125:95], vel_x[157:126], vel_y[189:158], normal_x[207:190],
  // normal_y[225:208], face_end[226], zero fill[231:227]
  input  wire logic [231:0]         in_tdata,
  // tuser: mode (0 volume node, 1 face node)
  input  wire logic                 in_tuser,
  // tlast: element_end
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // tdata from bit 0: troubled[0], zero fill[7:1]
  output logic [7:0]                out_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       troubled;

  // take register writes at any time
  assign cfg_ready = 1'b1;

  kxrcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  kxrcf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (in_tuser),
    .in_last   (in_tlast),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .troubled  (troubled)
  );

  assign out_tdata = {7'b0, troubled};

endmodule
`default_nettype wire

// ===== test/kxrcf_troubled_cell_detect_unit_tb.sv =====
`timescale 1ns / 100ps
module kxrcf_troubled_cell_detect_unit_tb;
  import kxrcf_pkg::*;

  // one node request as it travels on the input channel
  typedef struct {
    bit                 mode;
    logic signed [31:0] d_in;
    logic signed [31:0] d_out;
    logic [30:0]        qw;
    logic [30:0]        jac;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    bit                 fend;
    bit                 eend;
  } node_t;

  // Tracks the element sums and holds the flags still owed by the unit.
  class flag_scoreboard;
    logic [31:0]        thr;
    logic [2:0]         faces;
    logic [63:0]        peak;
    logic [63:0]        area;
    logic signed [63:0] fflow;
    logic signed [63:0] fjump;
    logic [63:0]        flen;
    logic signed [63:0] jtot;
    logic [63:0]        ltot;
    bit                 flags_due[$];
    int                 errors;
    int                 mismatches;

    function new();
      thr = THRESHOLD_RST;
      faces = FACE_COUNT_RST;
      errors = 0;
      mismatches = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      peak = 0;
      area = 0;
      fflow = 0;
      fjump = 0;
      flen = 0;
      jtot = 0;
      ltot = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_THRESHOLD) thr = val;
      else if (idx == REG_FACE_COUNT) faces = val[2:0];
    endfunction

    // Q product, floored, clamped to signed 64 bit
    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] p;
      p = a * b;
      p = p >>> FRAC_BITS;
      if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return p[63:0];
    endfunction

    function logic signed [63:0] sat_s(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
    endfunction

    function logic [63:0] sat_u(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function bit troubled_flag();
      logic [383:0] lhs;
      logic [383:0] rhs;
      logic [63:0]  jmag;
      logic [2:0]   c;
      c = (faces <= FACE_LIMIT) ? FACE_LIMIT - faces : 3'd0;
      jmag = jtot[63] ? 64'd0 - jtot : jtot;
      lhs = 384'(jmag);
      lhs = lhs * lhs;
      lhs = lhs << (5 * FRAC_BITS);
      rhs = 384'(thr) * 384'(ltot);
      rhs = rhs * 384'(peak);
      rhs = rhs * rhs;
      rhs = rhs * 384'(c);
      rhs = rhs * 384'(area);
      return lhs > rhs;
    endfunction

    // advance the element state by one accepted request
    function void note_request(node_t n);
      logic signed [63:0] wj;
      logic signed [63:0] vn;
      logic [63:0]        m;
      wj = qmul($signed({33'b0, n.qw}), $signed({33'b0, n.jac}));
      if (!n.mode) begin
        m = n.d_in[31] ? 64'd0 - 64'(n.d_in) : 64'(n.d_in);
        if (m > peak) peak = m;
        area = sat_u(area, wj);
      end else begin
        vn = sat_s(qmul(64'(n.nx), 64'(n.vx)), qmul(64'(n.ny), 64'(n.vy)));
        fflow = sat_s(fflow, qmul(wj, vn));
        fjump = sat_s(fjump, qmul(wj, 64'(n.d_in) - 64'(n.d_out)));
        flen = sat_u(flen, wj);
        if (n.fend) begin
          if (fflow < 0) begin
            jtot = sat_s(jtot, fjump);
            ltot = sat_u(ltot, flen);
          end
          fflow = 0;
          fjump = 0;
          flen = 0;
        end
      end
      if (n.eend) begin
        flags_due.push_back(troubled_flag());
        clear_sums();
      end
    endfunction

    function void check_flag(logic [7:0] got);
      bit want;
      if (flags_due.size() == 0) begin
        errors++;
        $display("unexpected flag %h at %0t", got, $realtime);
        return;
      end
      want = flags_due.pop_front();
      if (got[0] !== want) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("troubled mismatch at %0t: expected %0d, got %0b", $realtime, want, got[0]);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [231:0]         in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  flag_scoreboard sb = new();

  always #1 clk = ~clk;

  kxrcf_troubled_cell_detect_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Hold a request after a random gap until the unit takes it. Valid is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_node(node_t n);
    int gap;
    gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= n.mode;
    in_tlast  <= n.eend;
    in_tdata  <= {5'b0, n.fend, n.ny, n.nx, n.vy, n.vx, n.jac, n.qw, n.d_out, n.d_in};
    do @(posedge clk); while (!in_tready);
    sb.note_request(n);
  endtask

  // Drain every owed flag, then let the unit settle before a register write.
  task automatic drain_unit();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.flags_due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Data value: mostly plausible Q16.16 depths and speeds, some extremes.
  function automatic logic [31:0] pick_data(bit positive);
    case ($urandom % 8)
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return positive ? $urandom_range(0, 5 * 65536)
                               : $urandom_range(0, 6 * 65536) - 3 * 65536;
    endcase
  endfunction

  function automatic logic [30:0] pick_weight();
    case ($urandom % 10)
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      2: return 31'd0;
      default: return 31'($urandom_range(0, 2 * 65536));
    endcase
  endfunction

  function automatic logic [17:0] pick_normal();
    case ($urandom % 6)
      0: return 18'sd65536;
      1: return -18'sd65536;
      default: return 18'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  function automatic node_t random_node(bit mode, bit fend, bit eend);
    node_t n;
    n.mode  = mode;
    n.d_in  = pick_data(1'b1);
    n.d_out = pick_data(1'b1);
    n.qw    = pick_weight();
    n.jac   = pick_weight();
    n.vx    = pick_data(1'b0);
    n.vy    = pick_data(1'b0);
    n.nx    = pick_normal();
    n.ny    = pick_normal();
    n.fend  = fend;
    n.eend  = eend;
    return n;
  endfunction

  // One well-formed element: volume nodes, then each face's nodes; returns
  // the number of requests sent. Now and then break the sequence.
  task automatic send_element(output int sent);
    int nvol;
    int nodes;
    int fc;
    bit broken;
    node_t n;
    sent = 0;
    broken = ($urandom % 10) == 0;
    fc = int'(sb.faces);
    nvol = $urandom_range(1, 4);
    for (int i = 0; i < nvol; i++) begin
      send_node(random_node(1'b0, 1'($urandom % 2), 1'b0));
      sent++;
    end
    for (int f = 0; f < fc; f++) begin
      nodes = $urandom_range(1, 3);
      for (int k = 0; k < nodes; k++) begin
        n = random_node(1'b1, k == nodes - 1, 1'b0);
        if (broken) begin
          n.mode = 1'($urandom % 2);
          n.fend = 1'($urandom % 2);
        end
        n.eend = (f == fc - 1) && (k == nodes - 1);
        if (broken && ($urandom % 4) == 0) n.eend = 1'b1;
        send_node(n);
        sent++;
        if (n.eend) return;
      end
    end
  endtask

  task automatic directed_nodes();
    node_t n;
    // lone volume node that ends the element
    n = random_node(1'b0, 1'b1, 1'b1);
    n.d_in = 32'h8000_0000;
    send_node(n);
    // extremes on every field, inflow face that closes
    n = random_node(1'b0, 1'b0, 1'b0);
    n.d_in = 32'h7FFF_FFFF; n.qw = 31'h7FFF_FFFF; n.jac = 31'h7FFF_FFFF;
    send_node(n);
    n = random_node(1'b1, 1'b1, 1'b0);
    n.d_in = 32'h7FFF_FFFF; n.d_out = 32'h8000_0000;
    n.qw = 31'h7FFF_FFFF; n.jac = 31'h7FFF_FFFF;
    n.vx = 32'h7FFF_FFFF; n.vy = 32'h7FFF_FFFF; n.nx = -18'sd65536; n.ny = -18'sd65536;
    send_node(n);
    n = random_node(1'b1, 1'b1, 1'b1);
    n.d_in = 32'h8000_0000; n.d_out = 32'h7FFF_FFFF;
    n.vx = 32'h8000_0000; n.vy = 32'h8000_0000; n.nx = 18'sd65536; n.ny = 18'sd65536;
    send_node(n);
    // all-zero element
    n = '{default: 0};
    send_node(n);
    n.mode = 1'b1; n.fend = 1'b1; n.eend = 1'b1;
    send_node(n);
    // plain triangle with inflow on every face
    for (int f = 0; f < 4; f++) begin
      n = random_node(f == 0 ? 1'b0 : 1'b1, 1'b1, f == 3);
      n.d_in = 32'h0001_0000 + f * 32'h4000; n.d_out = 32'h0000_8000;
      n.qw = 31'h0000_8000; n.jac = 31'h0001_0000;
      n.vx = -32'sh0001_0000; n.vy = '0; n.nx = 18'sd65536; n.ny = '0;
      send_node(n);
    end
    // element end inside an open face
    send_node(random_node(1'b0, 1'b0, 1'b0));
    send_node(random_node(1'b1, 1'b0, 1'b0));
    send_node(random_node(1'b1, 1'b0, 1'b1));
    // outflow face then face closed on the end request
    n = random_node(1'b1, 1'b1, 1'b0);
    n.vx = 32'sh0002_0000; n.nx = 18'sd65536; n.ny = '0; n.qw = 31'h1_0000; n.jac = 31'h1_0000;
    send_node(n);
    n.vx = -32'sh0002_0000; n.eend = 1'b1;
    send_node(n);
  endtask

  // Result side: stall at random before taking each flag.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_flag(out_tdata);
    end
  end

  initial begin
    int sent;
    int total;
    logic [31:0] thr_set [5];
    logic [2:0]  fc_set [5];
    thr_set = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0003_0000};
    fc_set  = '{3'd3, 3'd4, 3'd3, 3'd4, 3'd3};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_nodes();
    for (int ph = 0; ph < 6; ph++) begin
      // pause until every owed flag is back, then retune
      drain_unit();
      if (ph < 5) begin
        write_reg(REG_THRESHOLD, thr_set[ph]);
        write_reg(REG_FACE_COUNT, 32'(fc_set[ph]));
      end else begin
        write_reg(REG_THRESHOLD, $urandom);
        write_reg(REG_FACE_COUNT, 3'd3 + ($urandom % 2));
      end
      total = 0;
      while (total < 250) begin
        if (($urandom % 12) == 0) begin
          send_node(random_node(1'($urandom % 2), 1'($urandom % 2), ($urandom % 3) == 0));
          total++;
        end else begin
          send_element(sent);
          total += sent;
        end
      end
    end
    drain_unit();
    if (sb.flags_due.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
